@@ rtl/assert_macros.svh @@
// Assertion macros for RTL that checks its own logic (used by tga_rle_decoder).
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition implies a consequence in the next clock cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/trle_pkg.sv @@
// Shared types and constants for the TGA run-length decoder.
// No dependencies; used by trle_step and tga_rle_decoder.
package trle_pkg;

    // Field and register widths
    localparam int BPP_W   = 3;
    localparam int CNT_W   = 32;
    localparam int PIX_W   = 32;
    localparam int REP_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int MAX_BPP = 4;

    // Configuration register indexes
    localparam logic [0:0] REG_BPP         = 1'b0;
    localparam logic [0:0] REG_PIXEL_COUNT = 1'b1;

    // Register reset values
    localparam logic [BPP_W-1:0] BPP_RESET         = 3'd3;
    localparam logic [CNT_W-1:0] PIXEL_COUNT_RESET = 32'd1;

    // Packet header coding: below RUN_BASE is raw, else run of header - RUN_BIAS
    localparam logic [BYTE_W-1:0] RUN_BASE = 8'd128;
    localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd127;

    typedef enum logic {
        PH_HEADER,
        PH_PIXEL
    } phase_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic [REP_W-1:0] repeat_count;
        logic             frame_end;
        logic             overflow_error;
    } result_t;

endpackage

@@ rtl/trle_step.sv @@
// Per-byte decode step: packet state, pixel gathering and frame counting.
// Depends on trle_pkg.
module trle_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [trle_pkg::BYTE_W-1:0] data_byte,
    input  logic [trle_pkg::BPP_W-1:0]  cfg_bpp,
    input  logic [trle_pkg::CNT_W-1:0]  cfg_pixel_count,
    output logic                        res_valid,
    output trle_pkg::result_t           res
);

    trle_pkg::phase_t              phase_reg, phase_next;
    logic                          is_run_reg, is_run_next;
    logic [trle_pkg::REP_W-1:0]    left_reg, left_next;
    logic [1:0]                    slot_reg, slot_next;
    logic [trle_pkg::PIX_W-1:0]    gather_reg, gather_next;
    logic [trle_pkg::CNT_W-1:0]    done_reg, done_next;

    logic [trle_pkg::BPP_W-1:0]    bpp_eff;
    logic                          is_header;
    logic [trle_pkg::PIX_W-1:0]    gather_upd;
    logic [2:0]                    slot_inc;
    logic                          pixel_done;
    logic [trle_pkg::REP_W-1:0]    rep_n;
    logic [trle_pkg::CNT_W:0]      total;
    logic                          over;
    logic [trle_pkg::REP_W-1:0]    left_dec;
    logic                          pkt_end;
    logic                          frame_hit;

    // Clamp bytes per pixel into 1..MAX_BPP
    always_comb begin
        bpp_eff = cfg_bpp;
        if (cfg_bpp == '0) begin
            bpp_eff = trle_pkg::BPP_W'(1);
        end else if (cfg_bpp > trle_pkg::BPP_W'(trle_pkg::MAX_BPP)) begin
            bpp_eff = trle_pkg::BPP_W'(trle_pkg::MAX_BPP);
        end
    end

    // Shared decode of the current byte
    assign is_header  = (phase_reg == trle_pkg::PH_HEADER);
    assign gather_upd = gather_reg
                      | ({{(trle_pkg::PIX_W-trle_pkg::BYTE_W){1'b0}}, data_byte}
                         << {slot_reg, 3'b000});
    assign slot_inc   = {1'b0, slot_reg} + 3'd1;
    assign pixel_done = !is_header && !(slot_inc < bpp_eff);
    assign rep_n      = is_run_reg ? left_reg : trle_pkg::REP_W'(1);
    assign total      = {1'b0, done_reg} + {{(trle_pkg::CNT_W+1-trle_pkg::REP_W){1'b0}}, rep_n};
    assign over       = total > {1'b0, cfg_pixel_count};
    assign left_dec   = is_run_reg ? '0 : left_reg - trle_pkg::REP_W'(1);
    assign pkt_end    = over || (left_dec == '0);
    assign frame_hit  = (total[trle_pkg::CNT_W-1:0] == cfg_pixel_count);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (en) begin
            case (phase_reg)
                trle_pkg::PH_HEADER: phase_next = trle_pkg::PH_PIXEL;
                trle_pkg::PH_PIXEL: begin
                    if (pixel_done && pkt_end) begin
                        phase_next = trle_pkg::PH_HEADER;
                    end
                end
                default: phase_next = trle_pkg::PH_HEADER;
            endcase
        end
    end

    // Datapath state and result
    always_comb begin
        is_run_next = is_run_reg;
        left_next   = left_reg;
        slot_next   = slot_reg;
        gather_next = gather_reg;
        done_next   = done_reg;
        res_valid   = 1'b0;
        res         = '0;
        if (en) begin
            if (is_header) begin
                // load packet kind and length
                slot_next   = '0;
                gather_next = '0;
                if (data_byte < trle_pkg::RUN_BASE) begin
                    is_run_next = 1'b0;
                    left_next   = data_byte + trle_pkg::REP_W'(1);
                end else begin
                    is_run_next = 1'b1;
                    left_next   = data_byte - trle_pkg::RUN_BIAS;
                end
            end else if (!pixel_done) begin
                // gather one more byte
                slot_next   = slot_inc[1:0];
                gather_next = gather_upd;
            end else begin
                slot_next   = '0;
                gather_next = '0;
                res_valid   = 1'b1;
                if (over) begin
                    // drop the pixel, abandon the packet and clear the count
                    res.overflow_error = 1'b1;
                    done_next          = '0;
                    is_run_next        = 1'b0;
                    left_next          = '0;
                end else begin
                    res.pixel_value  = gather_upd;
                    res.repeat_count = rep_n;
                    res.frame_end    = frame_hit;
                    done_next        = total[trle_pkg::CNT_W-1:0];
                    left_next        = left_dec;
                    if (left_dec == '0) begin
                        is_run_next = 1'b0;
                        if (frame_hit) begin
                            done_next = '0;
                        end
                    end
                end
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= trle_pkg::PH_HEADER;
            is_run_reg <= 1'b0;
            left_reg   <= '0;
            slot_reg   <= '0;
            gather_reg <= '0;
            done_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            is_run_reg <= is_run_next;
            left_reg   <= left_next;
            slot_reg   <= slot_next;
            gather_reg <= gather_next;
            done_reg   <= done_next;
        end
    end

endmodule

@@ rtl/tga_rle_decoder.sv @@
// TGA run-length decoder: one coded byte per transfer in, one pixel or run out.
// An input transfer waits in the input register, then the decode step loads the
// result register that drives m_tvalid. Throughput: one byte per cycle, held off
// while a pending result is not taken on m_tready.
// Reset (aresetn low, synchronous): 3 bytes/pixel, 1-pixel frame, count cleared,
// decoder waits for a packet header. Depends on trle_pkg, trle_step, assert_macros.svh.
`include "assert_macros.svh"

module tga_rle_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [0:0]                  cfg_addr,
    input  logic [trle_pkg::CNT_W-1:0]  cfg_wdata,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] data_byte
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    output logic                        m_tlast,   // frame_end
    output logic                        m_tuser    // [0] overflow_error
);

    logic [trle_pkg::BPP_W-1:0]  bpp_reg;
    logic [trle_pkg::CNT_W-1:0]  pixel_count_reg;

    logic                        in_valid_reg;
    logic [trle_pkg::BYTE_W-1:0] in_data_reg;
    logic                        out_valid_reg;
    trle_pkg::result_t           out_data_reg;

    logic                        advance;
    logic                        res_valid;
    trle_pkg::result_t           res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg         <= trle_pkg::BPP_RESET;
            pixel_count_reg <= trle_pkg::PIXEL_COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                trle_pkg::REG_BPP:         bpp_reg <= cfg_wdata[trle_pkg::BPP_W-1:0];
                trle_pkg::REG_PIXEL_COUNT: pixel_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Process the held byte when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register: take a transfer, drop it once processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    trle_step u_step (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (advance),
        .data_byte       (in_data_reg),
        .cfg_bpp         (bpp_reg),
        .cfg_pixel_count (pixel_count_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Result register: load on advance, clear after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.repeat_count, out_data_reg.pixel_value};
    assign m_tlast  = out_data_reg.frame_end;
    assign m_tuser  = out_data_reg.overflow_error;

    // Self checks
    `ASSERT_CLK(a_ovf_zero, aclk, aresetn,
        (out_valid_reg && out_data_reg.overflow_error) |->
        (out_data_reg.pixel_value == '0 && out_data_reg.repeat_count == '0 &&
         !out_data_reg.frame_end), "overflow result carries nonzero fields")
    `ASSERT_CLK(a_rep_nonzero, aclk, aresetn,
        (out_valid_reg && !out_data_reg.overflow_error) |->
        (out_data_reg.repeat_count != '0), "pixel result with zero repeat count")
    `ASSERT_NEXT(a_in_hold, aclk, aresetn,
        (in_valid_reg && !advance), in_valid_reg, "held input byte lost")

endmodule

@@ tb/tga_rle_result_checker.sv @@
// Checker for the TGA run-length decoder: tracks register writes and stream transfers,
// predicts each pixel or run result and compares it with the result channel.
// Depends on trle_pkg for the result layout, register indexes and header coding.
module tga_rle_result_checker
    import trle_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_addr,
    input  logic [CNT_W-1:0]  cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    input  logic              m_tlast,   // frame_end
    input  logic              m_tuser,   // [0] overflow_error
    output int                fail_count,
    output int                pending,
    output int                checked,
    output int                frame_ends,
    output int                overflows
);

    // Register copies
    logic [BPP_W-1:0] bpp_reg;
    logic [CNT_W-1:0] frame_pixels;

    // Decoder state
    phase_t           phase;
    logic             run_pkt;
    logic [7:0]       pkt_left;
    logic [1:0]       slot;
    logic [PIX_W-1:0] gather;
    logic [CNT_W-1:0] done_pixels;

    result_t pixel_q[$];
    int      fails;
    int      n_checked;
    int      n_ends;
    int      n_errs;

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        frame_ends = 0;
        overflows  = 0;
    end

    // Return to the header phase, dropping any partial packet
    function automatic void await_header();
        phase    = PH_HEADER;
        run_pkt  = 1'b0;
        pkt_left = '0;
        slot     = '0;
        gather   = '0;
    endfunction

    // Advance the decoder by one coded byte; returns 1 when a result is due
    function automatic logic decode_byte(input logic [7:0] b, output result_t r);
        int               width;
        logic [7:0]       n;
        logic [CNT_W:0]   total;
        logic [PIX_W-1:0] val;
        r = '0;
        width = int'(bpp_reg);
        if (width == 0) width = 1;
        if (width > MAX_BPP) width = MAX_BPP;

        // Header: set up the packet, no result
        if (phase != PH_PIXEL) begin
            run_pkt  = (b >= RUN_BASE);
            pkt_left = run_pkt ? b - RUN_BIAS : b + 8'd1;
            phase    = PH_PIXEL;
            slot     = '0;
            gather   = '0;
            return 1'b0;
        end

        // Gather little-endian bytes until the pixel is whole
        gather = gather | ({24'd0, b} << (8 * slot));
        if (slot + 1 < width) begin
            slot = slot + 2'd1;
            return 1'b0;
        end

        val    = gather;
        slot   = '0;
        gather = '0;
        n      = run_pkt ? pkt_left : 8'd1;
        total  = {1'b0, done_pixels} + {25'd0, n};

        // Count passed: drop the pixel and restart the frame
        if (total > {1'b0, frame_pixels}) begin
            r.overflow_error = 1'b1;
            done_pixels      = '0;
            await_header();
            return 1'b1;
        end

        done_pixels    = total[CNT_W-1:0];
        r.pixel_value  = val;
        r.repeat_count = n;
        r.frame_end    = (done_pixels == frame_pixels);
        pkt_left       = run_pkt ? 8'd0 : pkt_left - 8'd1;
        if (pkt_left == 8'd0) begin
            if (done_pixels == frame_pixels) done_pixels = '0;
            await_header();
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            bpp_reg      = BPP_RESET;
            frame_pixels = PIXEL_COUNT_RESET;
            done_pixels  = '0;
            await_header();
            pixel_q.delete();
        end else begin
            // Compare the result transfer with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[39:32], m_tlast, m_tuser};
                if (pixel_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: expected none, %s %h rep %0d end %b err %b",
                             $time, "actual pixel", got.pixel_value, got.repeat_count,
                             got.frame_end, got.overflow_error);
                end else begin
                    want = pixel_q.pop_front();
                    n_checked++;
                    if (want.frame_end) n_ends++;
                    if (want.overflow_error) n_errs++;
                    if (got !== want) begin
                        fails++;
                        $display("%0t: result mismatch: expected pixel %h rep %0d end %b err %b,",
                                 $time, want.pixel_value, want.repeat_count, want.frame_end,
                                 want.overflow_error);
                        $display("%0t:   actual pixel %h rep %0d end %b err %b",
                                 $time, got.pixel_value, got.repeat_count,
                                 got.frame_end, got.overflow_error);
                    end
                end
            end

            // Track register writes, effective at once
            if (cfg_wr_en) begin
                if (cfg_addr == REG_BPP) bpp_reg = cfg_wdata[BPP_W-1:0];
                else if (cfg_addr == REG_PIXEL_COUNT) frame_pixels = cfg_wdata;
            end

            // Predict from each accepted coded byte
            if (s_tvalid && s_tready) begin
                if (decode_byte(s_tdata, want)) pixel_q.push_back(want);
            end
        end
        fail_count <= fails;
        pending    <= pixel_q.size();
        checked    <= n_checked;
        frame_ends <= n_ends;
        overflows  <= n_errs;
    end

endmodule

@@ tb/tga_rle_decoder_test.sv @@
// Testbench top for the TGA run-length decoder: clock, reset, register writes, coded
// byte stream and result back-pressure. Depends on trle_pkg, tga_rle_decoder and
// tga_rle_result_checker, which does all prediction and comparison.
module tga_rle_decoder_test;
    import trle_pkg::*;

    localparam int ITEMS       = 1450;
    localparam int WATCHDOG    = 2000;
    localparam int HOLD_CYCLES = 300;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [0:0]        cfg_addr  = REG_BPP;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // [7:0] data_byte
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;          // [31:0] pixel_value, [39:32] repeat_count
    logic              m_tlast;          // frame_end
    logic              m_tuser;          // [0] overflow_error

    int fail_count;
    int pending;
    int checked;
    int frame_ends;
    int overflows;

    int          n_items    = 0;
    int          n_settings = 0;
    int          idle_cycles = 0;
    bit          tx_gaps    = 1'b1;
    bit          rx_stalls  = 1'b1;
    bit          hold_rx    = 1'b0;
    int          px_bytes   = 3;
    logic [31:0] frame_size = 32'd1;
    logic [31:0] frame_left = 32'd1;

    tga_rle_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    tga_rle_result_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .frame_ends (frame_ends),
        .overflows  (overflows)
    );

    always #5 aclk = ~aclk;

    // Abort when nothing has been transferred for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Watchdog expired at %0t", $time);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall before each transfer, one long hold on request
    initial begin : result_sink
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
            end
            gap = rx_stalls ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // Offer one coded byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        n_items++;
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CNT_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stop offering, wait for every predicted result, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_format(input logic [BPP_W-1:0] bpp, input logic [CNT_W-1:0] cnt);
        write_reg(REG_BPP, {{(CNT_W-BPP_W){1'b0}}, bpp});
        write_reg(REG_PIXEL_COUNT, cnt);
        px_bytes = int'(bpp);
        if (px_bytes == 0) px_bytes = 1;
        if (px_bytes > MAX_BPP) px_bytes = MAX_BPP;
        frame_size = cnt;
        frame_left = cnt;
        n_settings++;
    endtask

    task automatic send_pixel();
        for (int k = 0; k < px_bytes; k++) send_byte(8'($urandom_range(0, 255)));
    endtask

    // One packet sized mostly to fit the frame, sometimes too long
    task automatic send_packet();
        int lim;
        int len;
        lim = (frame_left == 0 || frame_left > 128) ? 128 : frame_left;
        if ($urandom_range(0, 9) == 0) lim = 128;
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 7) != 0 && lim > 8) lim = 8;
            len = $urandom_range(1, lim);
            send_byte(8'(len - 1));
            for (int p = 0; p < len; p++) send_pixel();
        end else begin
            len = $urandom_range(1, lim);
            send_byte(8'(len + RUN_BIAS));
            send_pixel();
        end
        if (len > frame_left) frame_left = frame_size;
        else frame_left = frame_left - len;
        if (frame_left == 0) frame_left = frame_size;
    endtask

    initial begin : stimulus
        int               phase_len;
        int               start;
        logic [BPP_W-1:0] bpp;
        logic [CNT_W-1:0] cnt;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset format: three-byte pixel completing a one-pixel frame
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();

        // Widest pixel, longest run and shortest run in the largest frame
        set_format(3'd4, 32'hFFFF_FFFF);
        for (int k = 0; k < 5; k++) send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        send_byte(8'h04);
        drain();

        // Width zero acts as one; a run that passes the count is dropped
        set_format(3'd0, 32'd3);
        send_byte(8'h01);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(8'h81);
        send_byte(8'h11);
        drain();

        // Raw packet longer than the frame: end flag, then overflow
        set_format(3'd1, 32'd2);
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        drain();

        // Width above the maximum acts as four; zero-size frame overflows
        set_format(3'd7, 32'd0);
        send_byte(8'h80);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'hC3);
        send_byte(8'h3C);
        drain();

        // Random settings, each followed by a stream of mostly well-formed packets
        while (n_items < ITEMS) begin
            bpp = ($urandom_range(0, 7) == 0) ? BPP_W'($urandom_range(0, 7))
                                              : BPP_W'($urandom_range(1, 4));
            case ($urandom_range(0, 9))
                6:       cnt = '0;
                7:       cnt = 32'hFFFF_FFFF;
                8:       cnt = $urandom;
                9:       cnt = $urandom_range(41, 400);
                default: cnt = $urandom_range(1, 40);
            endcase
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            // Back-pressure phase: steady input while the result side holds off
            if (n_settings == 7) begin
                bpp     = 3'd1;
                cnt     = 32'd100000;
                tx_gaps = 1'b0;
                hold_rx = 1'b1;
            end
            set_format(bpp, cnt);
            phase_len = $urandom_range(40, 150);
            start     = n_items;
            while (n_items - start < phase_len) begin
                if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
                else send_packet();
            end
            drain();
        end

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (10) @(posedge aclk);

        $display("Sent %0d coded bytes under %0d register settings, checked %0d results",
                 n_items, n_settings, checked);
        $display("Results included %0d frame ends and %0d overflow drops",
                 frame_ends, overflows);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/trle_pkg.sv
rtl/trle_step.sv
rtl/tga_rle_decoder.sv
tb/tga_rle_result_checker.sv
tb/tga_rle_decoder_test.sv
